@@ rtl/pnorm_pkg.sv @@
// ----------------------------------------------------------------------------
// pnorm_pkg: shared definitions of the peak normalizer
// Widths, the control word format and the microprogram of the sequencer.
// ----------------------------------------------------------------------------
package pnorm_pkg;

   localparam int SAMPLE_W = 48;
   localparam int HALF_W   = 23;
   localparam int FRAC_W   = 32;
   localparam int CNT_W    = 5;
   localparam int PC_W     = 3;
   localparam int OUT_W    = 24;

   localparam logic [HALF_W-1:0] HALF_RANGE_RESET = 23'd7924465;

   // Microprogram step addresses.
   localparam logic [PC_W-1:0] STEP_TAKE   = 3'd0;
   localparam logic [PC_W-1:0] STEP_CHECK  = 3'd1;
   localparam logic [PC_W-1:0] STEP_RANGE  = 3'd2;
   localparam logic [PC_W-1:0] STEP_DIV    = 3'd3;
   localparam logic [PC_W-1:0] STEP_MUL_LO = 3'd4;
   localparam logic [PC_W-1:0] STEP_MUL_HI = 3'd5;
   localparam logic [PC_W-1:0] STEP_WAIT   = 3'd6;
   localparam logic [PC_W-1:0] STEP_FIN    = 3'd7;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_TAKE,
      OP_RANGE,
      OP_DIV,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_FIN
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_CONVERT,
      COND_MODE_SET,
      COND_NO_DIV,
      COND_DIV_MORE,
      COND_OUT_FULL
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [PC_W-1:0]   target;
      logic              take;
   } ctrl_word_type;

   typedef struct packed {
      logic convert_xfer;
      logic mode_set;
      logic no_div;
      logic div_more;
      logic out_full;
   } status_type;

   // Control store. A step jumps to its target when its condition holds,
   // otherwise it falls through to the next address (the last one wraps).
   function automatic ctrl_word_type ucode_word(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_NONE, cond: COND_NEVER, target: STEP_TAKE, take: 1'b0};
      case (pc)
         STEP_TAKE:   w = '{op: OP_TAKE,   cond: COND_NO_CONVERT, target: STEP_TAKE,
                            take: 1'b1};
         STEP_CHECK:  w = '{op: OP_NONE,   cond: COND_MODE_SET,   target: STEP_MUL_LO,
                            take: 1'b0};
         STEP_RANGE:  w = '{op: OP_RANGE,  cond: COND_NO_DIV,     target: STEP_MUL_LO,
                            take: 1'b0};
         STEP_DIV:    w = '{op: OP_DIV,    cond: COND_DIV_MORE,   target: STEP_DIV,
                            take: 1'b0};
         STEP_MUL_LO: w = '{op: OP_MUL_LO, cond: COND_NEVER,      target: STEP_TAKE,
                            take: 1'b0};
         STEP_MUL_HI: w = '{op: OP_MUL_HI, cond: COND_NEVER,      target: STEP_TAKE,
                            take: 1'b0};
         STEP_WAIT:   w = '{op: OP_NONE,   cond: COND_OUT_FULL,   target: STEP_WAIT,
                            take: 1'b0};
         STEP_FIN:    w = '{op: OP_FIN,    cond: COND_NEVER,      target: STEP_TAKE,
                            take: 1'b0};
         default:     w = '{op: OP_NONE,   cond: COND_NEVER,      target: STEP_TAKE,
                            take: 1'b0};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/pnorm_sequencer.sv @@
// ----------------------------------------------------------------------------
// pnorm_sequencer: microprogram sequencer
// Step counter, control store lookup and conditional jump selection.
// ----------------------------------------------------------------------------
module pnorm_sequencer (
   input  logic                      clock,
   input  logic                      reset,
   input  pnorm_pkg::status_type     status,
   output pnorm_pkg::ctrl_word_type  ctrl
);
   import pnorm_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            jump;

   always_comb begin
      ctrl = ucode_word(pc_ff);
      case (ctrl.cond)
         COND_NEVER:      jump = 1'b0;
         COND_NO_CONVERT: jump = ~status.convert_xfer;
         COND_MODE_SET:   jump = status.mode_set;
         COND_NO_DIV:     jump = status.no_div;
         COND_DIV_MORE:   jump = status.div_more;
         COND_OUT_FULL:   jump = status.out_full;
         default:         jump = 1'b0;
      endcase
      pc_in = jump ? ctrl.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_TAKE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ rtl/pnorm_datapath.sv @@
// ----------------------------------------------------------------------------
// pnorm_datapath: min/max tracking, scale division and scaling multiply
// Executes one control operation per cycle under the sequencer.
// ----------------------------------------------------------------------------
module pnorm_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pnorm_pkg::op_type                     op,
   input  logic                                  xfer,
   input  logic                                  req_action,
   input  logic signed [pnorm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                  req_first,
   input  logic                                  csr_we,
   input  logic [pnorm_pkg::HALF_W-1:0]          csr_wdata,
   output logic                                  mode_set,
   output logic                                  no_div,
   output logic                                  div_more,
   output logic [pnorm_pkg::OUT_W-1:0]           result,
   output logic                                  scaled
);
   import pnorm_pkg::*;

   logic signed [SAMPLE_W-1:0] min_ff, max_ff, sample_ff;
   logic [HALF_W-1:0]          half_ff;
   logic                       mode_set_ff, scaled_ff;
   logic [SAMPLE_W-1:0]        range_ff;
   logic [SAMPLE_W:0]          rem_ff;
   logic [FRAC_W-1:0]          frac_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       neg_ff;
   logic [16:0]                mh_ff;
   logic [63:0]                lowp_ff;
   logic [49:0]                hi_ff;

   logic [SAMPLE_W:0]   range_wide;
   logic [40:0]         num;
   logic [SAMPLE_W:0]   rem_sh;
   logic                rem_ge;
   logic [SAMPLE_W:0]   diff;
   logic [SAMPLE_W:0]   mag;
   logic [48:0]         mul_hi;
   logic [33:0]         q;
   logic                exact;
   logic [35:0]         fl, v;
   logic                adj;
   logic [OUT_W-1:0]    copy_val;

   always_comb begin
      range_wide = {max_ff[SAMPLE_W-1], max_ff} - {min_ff[SAMPLE_W-1], min_ff};
      num        = {1'b0, half_ff, 17'b0};
      no_div     = {8'b0, num} >= range_wide;
      rem_sh     = {rem_ff[SAMPLE_W-1:0], 1'b0};
      rem_ge     = rem_sh >= {1'b0, range_ff};
      div_more   = cnt_ff != {CNT_W{1'b1}};
      diff       = {sample_ff[SAMPLE_W-1], sample_ff} - {min_ff[SAMPLE_W-1], min_ff};
      mag        = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
      mul_hi     = frac_ff * mh_ff;

      // Floor of the scaled product, less half_range, truncated toward zero.
      q     = hi_ff[49:16];
      exact = (lowp_ff[31:0] == 32'b0) && (hi_ff[15:0] == 16'b0);
      fl    = neg_ff ? (36'd0 - {2'b0, q} - {35'b0, ~exact}) : {2'b0, q};
      v     = fl - {13'b0, half_ff};
      if (!exact && v[35]) begin
         v = v + 1'b1;
      end

      adj      = sample_ff[SAMPLE_W-1] && (sample_ff[15:0] != 16'b0);
      copy_val = sample_ff[39:16] + {{(OUT_W-1){1'b0}}, adj};
      result   = scaled_ff ? v[OUT_W-1:0] : copy_val;
      scaled   = scaled_ff;
      mode_set = mode_set_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff      <= '0;
         max_ff      <= '0;
         half_ff     <= HALF_RANGE_RESET;
         mode_set_ff <= 1'b0;
         scaled_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            half_ff     <= csr_wdata;
            mode_set_ff <= 1'b0;
         end
         case (op)
            OP_TAKE: begin
               if (xfer && !req_action) begin
                  mode_set_ff <= 1'b0;
                  if (req_first) begin
                     min_ff <= req_sample;
                     max_ff <= req_sample;
                  end else begin
                     if (req_sample > max_ff) max_ff <= req_sample;
                     if (req_sample < min_ff) min_ff <= req_sample;
                  end
               end
            end
            OP_RANGE: begin
               mode_set_ff <= 1'b1;
               scaled_ff   <= ~no_div;
            end
            default: begin
            end
         endcase
      end
   end

   // Payload registers of the sample capture, division and multiply steps.
   always_ff @(posedge clock) begin
      case (op)
         OP_TAKE: begin
            if (xfer) sample_ff <= req_sample;
         end
         OP_RANGE: begin
            range_ff <= range_wide[SAMPLE_W-1:0];
            rem_ff   <= {8'b0, num};
            frac_ff  <= '0;
            cnt_ff   <= '0;
         end
         OP_DIV: begin
            rem_ff  <= rem_ge ? rem_sh - {1'b0, range_ff} : rem_sh;
            frac_ff <= {frac_ff[FRAC_W-2:0], rem_ge};
            cnt_ff  <= cnt_ff + 1'b1;
         end
         OP_MUL_LO: begin
            neg_ff  <= diff[SAMPLE_W];
            mh_ff   <= mag[SAMPLE_W:32];
            lowp_ff <= frac_ff * mag[31:0];
         end
         OP_MUL_HI: begin
            hi_ff <= {1'b0, mul_hi} + {18'b0, lowp_ff[63:32]};
         end
         default: begin
         end
      endcase
   end

endmodule

@@ rtl/peak_normalize_to_24bit_unit.sv @@
// ----------------------------------------------------------------------------
// peak_normalize_to_24bit_unit: two-pass peak normalizer to 24-bit PCM
// A scan pass tracks the sample range; a convert pass scales each sample so
// that the block spans plus and minus half_range, and emits three bytes.
// ----------------------------------------------------------------------------
// Usage: samples arrive on the req_ channel (valid/stall). A scan transfer
// (action 0) updates the minimum and maximum and produces no result. A
// convert transfer (action 1) produces one result on the rsp_ channel: the
// low 24 bits as three bytes and a flag that tells whether the scale below
// one was applied. The first convert after a scan or a csr_ write computes
// the scale by a bit-serial restoring division of 32 steps, which is skipped
// if the copy mode is chosen. Later converts run two multiply steps for the
// partial products, an output check and the output write. Only one item
// is in work at a time; req_stall is high until the result is registered.
// If rsp_stall holds a result, the sequencer waits before writing the next.
// A synchronous reset restores half_range to 7924465, clears the range to
// zero and drops any pending result.
// ----------------------------------------------------------------------------
module peak_normalize_to_24bit_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic signed [pnorm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                  req_first,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_byte_low,
   output logic [7:0]                            rsp_byte_mid,
   output logic [7:0]                            rsp_byte_high,
   output logic                                  rsp_was_scaled,
   input  logic                                  csr_we,
   input  logic [pnorm_pkg::HALF_W-1:0]          csr_wdata
);
   import pnorm_pkg::*;

   ctrl_word_type      ctrl;
   status_type         status;
   logic               xfer;
   logic               mode_set, no_div, div_more, scaled;
   logic [OUT_W-1:0]   result;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [OUT_W-1:0]   rsp_data_ff;
   logic               rsp_scaled_ff;

   assign req_stall = ~ctrl.take;
   assign xfer      = req_valid & ctrl.take;

   always_comb begin
      status.convert_xfer = xfer & req_action;
      status.mode_set     = mode_set;
      status.no_div       = no_div;
      status.div_more     = div_more;
      status.out_full     = rsp_valid_ff & rsp_stall;
   end

   pnorm_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   pnorm_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (ctrl.op),
      .xfer       (xfer),
      .req_action (req_action),
      .req_sample (req_sample),
      .req_first  (req_first),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .mode_set   (mode_set),
      .no_div     (no_div),
      .div_more   (div_more),
      .result     (result),
      .scaled     (scaled)
   );

   // The output register is loaded only once the previous transfer is gone.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (ctrl.op == OP_FIN) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == OP_FIN) begin
         rsp_data_ff   <= result;
         rsp_scaled_ff <= scaled;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_low   = rsp_data_ff[7:0];
   assign rsp_byte_mid   = rsp_data_ff[15:8];
   assign rsp_byte_high  = rsp_data_ff[23:16];
   assign rsp_was_scaled = rsp_scaled_ff;

endmodule
